// File: sv/min_tracking_stack_assert.svh
// Assertion macros for the min tracking stack.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// same-cycle implication
`define MTS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mts_pkg.sv
// Types and constants shared by the min tracking stack modules.
package mts_pkg;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic signed [31:0] min_incl;
		logic signed [31:0] min_below;
	} mts_entry_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic signed [31:0] min_value;
		logic               is_empty;
		logic               error;
	} mts_result_t;

endpackage

// File: sv/min_tracking_stack.sv
// Min tracking stack top level: stack core and output buffer.
//
//   channel  beat fields                                   handshake
//   in       kind, value                                   in_valid / in_ready
//   out      popped_value, min_value, is_empty, error      out_valid / out_ready
//
// One beat per cycle while in_ready is high; each result is registered in the output buffer.
// The top entry sits in registers, so back-to-back pops read the RAM one step ahead.
// Reset empties the stack at once; RAM contents are not cleared.
// The skid stage takes one more input beat while a result is stalled, then in_ready drops.
`include "min_tracking_stack_assert.svh"

module min_tracking_stack #(
	parameter int STACK_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] min_value,
	output logic               is_empty,
	output logic               error
);

	mts_pkg::mts_result_t core_res;
	mts_pkg::mts_result_t out_res;
	logic                 in_fire;

	assign in_fire = in_valid && in_ready;

	mts_core #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.in_fire(in_fire),
		.kind   (kind),
		.value  (value),
		.result (core_res)
	);

	mts_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (core_res),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_res)
	);

	assign popped_value = out_res.popped_value;
	assign min_value    = out_res.min_value;
	assign is_empty     = out_res.is_empty;
	assign error        = out_res.error;

	`MTS_ASSERT_IMP(a_err_no_pop, clk, arst_n, out_valid && error, popped_value == 32'sd0, "error beat carries a popped value")
	`MTS_ASSERT_IMP(a_empty_min, clk, arst_n, out_valid && is_empty, min_value == 32'sd0, "empty stack reports nonzero minimum")
	`MTS_ASSERT_IMP(a_skid_order, clk, arst_n, !in_ready, out_valid, "skid holds a beat while result register is empty")
	`MTS_ASSERT_NXT(a_skid_fill, clk, arst_n, in_valid && in_ready && out_valid && !out_ready, !in_ready, "stalled result did not fill skid")

endmodule

// File: sv/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/mts_core.sv
// Stack control: top entry in registers, lower entries in RAM, result logic.
module mts_core #(
	parameter int STACK_DEPTH = 128
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic [1:0]          kind,
	input  logic signed [31:0]  value,
	output mts_pkg::mts_result_t result
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int EW = $bits(mts_pkg::mts_entry_t);

	logic [CW-1:0]        count_q;
	logic                 sel_q;
	mts_pkg::mts_entry_t  top_q;
	mts_pkg::mts_entry_t  top_cur;
	mts_pkg::mts_entry_t  rd_entry;
	mts_pkg::mts_entry_t  new_entry;
	logic [EW-1:0]        rd_bits;
	logic [CW-1:0]        cnt_m1;
	logic [CW-1:0]        cnt_m2;
	logic                 empty;
	logic                 full;
	logic                 push_ok;
	logic                 pop_ok;
	logic                 ram_we;

	assign rd_entry = mts_pkg::mts_entry_t'(rd_bits);
	assign top_cur  = sel_q ? rd_entry : top_q;
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(STACK_DEPTH));
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);
	assign ram_we   = in_fire && push_ok && !empty;

	always_comb begin
		result    = '0;
		push_ok   = 1'b0;
		pop_ok    = 1'b0;
		new_entry = '0;
		unique case (kind)
			mts_pkg::KIND_PUSH: begin
				new_entry.value     = value;
				new_entry.min_below = empty ? 32'sd0 : top_cur.min_incl;
				new_entry.min_incl  = (empty || (value < top_cur.min_incl)) ?
					value : top_cur.min_incl;
				if (full) begin
					result.error     = 1'b1;
					result.min_value = top_cur.min_incl;
				end else begin
					push_ok          = 1'b1;
					result.min_value = new_entry.min_incl;
				end
			end
			mts_pkg::KIND_POP: begin
				if (empty) begin
					result.error    = 1'b1;
					result.is_empty = 1'b1;
				end else begin
					pop_ok              = 1'b1;
					result.popped_value = top_cur.value;
					result.min_value    = top_cur.min_below;
					result.is_empty     = (count_q == CW'(1));
				end
			end
			default: begin
				result.min_value = empty ? 32'sd0 : top_cur.min_incl;
				result.is_empty  = empty;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sel_q   <= 1'b0;
		end else if (in_fire && push_ok) begin
			count_q <= count_q + CW'(1);
			sel_q   <= 1'b0;
		end else if (in_fire && pop_ok) begin
			count_q <= cnt_m1;
			sel_q   <= 1'b1;
		end else begin
			sel_q   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push_ok) begin
			top_q <= new_entry;
		end else if (sel_q) begin
			top_q <= rd_entry;
		end
	end

	mts_ram #(
		.WIDTH(EW),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_m1[AW-1:0]),
		.wdata(EW'(top_cur)),
		.raddr(cnt_m2[AW-1:0]),
		.rdata(rd_bits)
	);

endmodule

// File: sv/mts_obuf.sv
// Result register with skid stage.
module mts_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mts_pkg::mts_result_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mts_pkg::mts_result_t out_data
);

	logic                 out_valid_q;
	logic                 skid_valid_q;
	mts_pkg::mts_result_t out_q;
	mts_pkg::mts_result_t skid_q;
	logic                 in_fire;
	logic                 out_fire;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_fire) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= in_fire;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end else if ((out_fire || !out_valid_q) && in_fire) begin
			out_q <= in_data;
		end
		if (in_fire && out_valid_q && !out_fire) begin
			skid_q <= in_data;
		end
	end

endmodule

// File: test/tb_min_tracking_stack.sv
// Testbench for min_tracking_stack: directed and random beats of all kinds vs a shadow stack.
module tb_min_tracking_stack;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	class min_stack_shadow;
		logic signed [31:0] value_mem [DEPTH];
		logic signed [31:0] min_mem [DEPTH];
		int unsigned count;
		int unsigned fails;
		mts_pkg::mts_result_t pending_results [$];

		function new();
			count = 0;
			fails = 0;
		endfunction

		function void apply_op(logic [1:0] k, logic signed [31:0] v);
			mts_pkg::mts_result_t res;
			res = '0;
			case (k)
				mts_pkg::KIND_PUSH: begin
					if (count >= DEPTH) begin
						res.error = 1'b1;
					end else begin
						value_mem[count] = v;
						if (count == 0 || v < min_mem[count - 1])
							min_mem[count] = v;
						else
							min_mem[count] = min_mem[count - 1];
						count++;
					end
				end
				mts_pkg::KIND_POP: begin
					if (count == 0) begin
						res.error = 1'b1;
					end else begin
						count--;
						res.popped_value = value_mem[count];
					end
				end
				default: ;
			endcase
			res.min_value = (count == 0) ? 32'sd0 : min_mem[count - 1];
			res.is_empty = (count == 0);
			pending_results.push_back(res);
		endfunction

		function void compare_result(mts_pkg::mts_result_t got);
			mts_pkg::mts_result_t want;
			if (pending_results.size() == 0) begin
				$error("result beat arrived with nothing outstanding");
				fails++;
				return;
			end
			want = pending_results.pop_front();
			if (got.popped_value !== want.popped_value) begin
				$error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
				fails++;
			end
			if (got.min_value !== want.min_value) begin
				$error("min_value: expected %0d, got %0d", want.min_value, got.min_value);
				fails++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
				fails++;
			end
			if (got.error !== want.error) begin
				$error("error: expected %0b, got %0b", want.error, got.error);
				fails++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         kind;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] popped_value;
	logic signed [31:0] min_value;
	logic               is_empty;
	logic               error;

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold = 0;
	int cycles = 0;
	min_stack_shadow shadow = new();

	min_tracking_stack #(
		.STACK_DEPTH(DEPTH)
	) u_dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.kind,
		.value,
		.out_valid,
		.out_ready,
		.popped_value,
		.min_value,
		.is_empty,
		.error
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// input beat is noted before the result check; results lag their input beats
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				shadow.apply_op(kind, value);
			if (out_valid && out_ready)
				shadow.compare_result({popped_value, min_value, is_empty, error});
		end
	end

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2, 3, 4: return 32'($urandom_range(16)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [1:0] pick_kind(int push_pct);
		int r;
		r = $urandom_range(99);
		if (r < push_pct)
			return mts_pkg::KIND_PUSH;
		else if (r < 95)
			return mts_pkg::KIND_POP;
		else if (r < 98)
			return mts_pkg::KIND_READ;
		else
			return KIND_SPARE;
	endfunction

	task automatic send_beat(input logic [1:0] k, input logic signed [31:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (shadow.pending_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		int push_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		kind = mts_pkg::KIND_PUSH;
		value = '0;
		tx_idle_pct = 31;
		rx_idle_pct = 65;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// empty stack corners, equal minimums, extremes, unused kind code
		send_beat(mts_pkg::KIND_POP, $urandom());
		send_beat(mts_pkg::KIND_READ, 32'sd0);
		send_beat(KIND_SPARE, $urandom());
		send_beat(mts_pkg::KIND_PUSH, 32'sd5);
		send_beat(mts_pkg::KIND_PUSH, 32'sd5);
		send_beat(mts_pkg::KIND_PUSH, 32'sd7);
		send_beat(mts_pkg::KIND_PUSH, 32'sh7fffffff);
		send_beat(mts_pkg::KIND_PUSH, -32'sd1);
		send_beat(mts_pkg::KIND_PUSH, 32'sh80000000);
		send_beat(mts_pkg::KIND_PUSH, 32'sh80000000);
		send_beat(mts_pkg::KIND_READ, $urandom());
		send_beat(KIND_SPARE, 32'sd0);
		repeat (8) send_beat(mts_pkg::KIND_POP, $urandom());
		send_beat(mts_pkg::KIND_READ, 32'sd0);

		for (int i = 0; i < 630; i++) begin
			if (i == 210) begin
				tx_idle_pct = 65;
				rx_idle_pct = 31;
			end
			if (i == 420) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (i == 100)
				rx_hold = 80;
			if (i == 300)
				wait_drained();
			// fill past full, drain past empty, then wander
			push_pct = (i < 170) ? 92 : (i < 380) ? 8 : 55;
			send_beat(pick_kind(push_pct), rand_value());
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (shadow.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
